// File: rtl/glb_pkg.sv
// glb_pkg: command beat type, operation and status codes for the grid lookup
// shared by glb_front, glb_queue, glb_back and grid_bilinear_lookup
package glb_pkg;

  localparam int SLOT_W = 6;

  typedef logic [2:0] op_t;
  typedef logic [2:0] status_t;

  localparam op_t OP_ERR   = 3'd0;
  localparam op_t OP_WR    = 3'd1;
  localparam op_t OP_EXACT = 3'd2;
  localparam op_t OP_LB    = 3'd3;
  localparam op_t OP_LT    = 3'd4;
  localparam op_t OP_BI    = 3'd5;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_BAD     = 3'd1;
  localparam status_t ST_UNKNOWN = 3'd2;
  localparam status_t ST_FEW     = 3'd3;
  localparam status_t ST_FULL    = 3'd4;

  typedef struct packed {
    op_t                op;
    status_t            status;
    logic [3:0]         wl;
    logic [SLOT_W-1:0]  b1;
    logic [SLOT_W-1:0]  b2;
    logic [SLOT_W-1:0]  t1;
    logic [SLOT_W-1:0]  t2;
    logic [15:0]        xb1;
    logic [15:0]        xb2;
    logic [15:0]        xt1;
    logic [15:0]        xt2;
    logic [15:0]        pb;
    logic [15:0]        pt;
    logic signed [31:0] value;
  } cmd_t;

endpackage

// File: rtl/grid_bilinear_lookup.sv
// grid_bilinear_lookup: latency table over (workload, batch, threads) with lookup
// and bilinear interpolation; depends on glb_pkg, glb_front, glb_queue, glb_back
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------------
//   input    | start, busy        | in_kind, in_workload, in_batch, in_threads, in_value
//   result   | out_valid (strobe) | out_result, out_status
//
// one item at a time; busy drops in the cycle that carries the item's result beat
// m = max(batch points, thread points); items bad or unknown at accept skip the axis
//   scan, all others scan m axis slots, each slot with a read and a compare state;
//   queries that pass the checks then read four cells; each interpolation runs the 48-step
//   bit-serial divider: one for a single-axis query, three when bilinear
// after reset a clearing pass writes every cell, WORKLOADS*AXIS_POINTS^2 of them,
// with busy high; the receiver cannot stall, each result beat lasts one cycle
module grid_bilinear_lookup import glb_pkg::*; #(
  parameter int WORKLOADS   = 16,
  parameter int AXIS_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [3:0]         in_workload,
  input  logic [15:0]        in_batch,
  input  logic [15:0]        in_threads,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic signed [31:0] out_result,
  output logic [2:0]         out_status
);

  logic acc;
  logic q_push, q_pop, q_empty, q_full;
  cmd_t q_din, q_dout;
  logic front_busy, back_busy;

  assign acc  = start & ~busy;
  assign busy = front_busy | ~q_empty | back_busy;

  glb_front #(.WORKLOADS(WORKLOADS), .AXIS_POINTS(AXIS_POINTS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_kind     (in_kind),
    .in_workload (in_workload),
    .in_batch    (in_batch),
    .in_threads  (in_threads),
    .in_value    (in_value),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_din       (q_din),
    .front_busy  (front_busy)
  );

  glb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full)
  );

  glb_back #(.WORKLOADS(WORKLOADS), .AXIS_POINTS(AXIS_POINTS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_dout     (q_dout),
    .q_pop      (q_pop),
    .back_busy  (back_busy),
    .out_valid  (out_valid),
    .out_result (out_result),
    .out_status (out_status)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full queue");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_result == 32'sd0))
    else $error("nonzero result with error status");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy low right after accept");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");

endmodule

// File: rtl/glb_ram.sv
// glb_ram: generic single write port, single read port RAM, registered read
// no dependencies
module glb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/glb_queue.sv
// glb_queue: two-entry command queue between front and back
// depends on glb_pkg
module glb_queue import glb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic empty,
  output logic full
);

  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  assign dout  = mem_r[rp_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

endmodule

// File: rtl/glb_front.sv
// glb_front: accepts items, scans both axes, appends new points, builds commands
// depends on glb_pkg and glb_ram
module glb_front import glb_pkg::*; #(
  parameter int WORKLOADS   = 16,
  parameter int AXIS_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic               in_kind,
  input  logic [3:0]         in_workload,
  input  logic [15:0]        in_batch,
  input  logic [15:0]        in_threads,
  input  logic signed [31:0] in_value,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_din,
  output logic               front_busy
);

  localparam int AW = $clog2(AXIS_POINTS);
  localparam int PW = $clog2(AXIS_POINTS + 1);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_RD   = 3'd1;
  localparam logic [2:0] F_CMP  = 3'd2;
  localparam logic [2:0] F_DEC  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] fslot;
    logic              lo1v;
    logic [15:0]       lo1;
    logic [SLOT_W-1:0] lo1s;
    logic              lo2v;
    logic [15:0]       lo2;
    logic [SLOT_W-1:0] lo2s;
    logic              hi1v;
    logic [15:0]       hi1;
    logic [SLOT_W-1:0] hi1s;
    logic              hi2v;
    logic [15:0]       hi2;
    logic [SLOT_W-1:0] hi2s;
  } trk_t;

  typedef struct packed {
    logic [SLOT_W-1:0] s1;
    logic [15:0]       x1;
    logic [SLOT_W-1:0] s2;
    logic [15:0]       x2;
  } brk_t;

  function automatic trk_t trk_step(trk_t t, logic [15:0] a, logic [SLOT_W-1:0] s,
                                    logic [15:0] p);
    trk_t r;
    r = t;
    if (a == p) begin
      r.found = 1'b1;
      r.fslot = s;
    end else if (a < p) begin
      if (!t.lo1v || a > t.lo1) begin
        r.lo2v = t.lo1v;
        r.lo2  = t.lo1;
        r.lo2s = t.lo1s;
        r.lo1v = 1'b1;
        r.lo1  = a;
        r.lo1s = s;
      end else if (!t.lo2v || a > t.lo2) begin
        r.lo2v = 1'b1;
        r.lo2  = a;
        r.lo2s = s;
      end
    end else begin
      if (!t.hi1v || a < t.hi1) begin
        r.hi2v = t.hi1v;
        r.hi2  = t.hi1;
        r.hi2s = t.hi1s;
        r.hi1v = 1'b1;
        r.hi1  = a;
        r.hi1s = s;
      end else if (!t.hi2v || a < t.hi2) begin
        r.hi2v = 1'b1;
        r.hi2  = a;
        r.hi2s = s;
      end
    end
    return r;
  endfunction

  function automatic brk_t bracket(trk_t t);
    brk_t r;
    if (!t.lo1v) begin
      r = '{s1: t.hi1s, x1: t.hi1, s2: t.hi2s, x2: t.hi2};
    end else if (!t.hi1v) begin
      r = '{s1: t.lo2s, x1: t.lo2, s2: t.lo1s, x2: t.lo1};
    end else begin
      r = '{s1: t.lo1s, x1: t.lo1, s2: t.hi1s, x2: t.hi1};
    end
    return r;
  endfunction

  logic [2:0]         state_r, state_nxt;
  logic               kind_r, kind_nxt;
  logic [3:0]         w_r, w_nxt;
  logic [15:0]        b_r, b_nxt;
  logic [15:0]        t_r, t_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [PW-1:0]      idx_r, idx_nxt;
  logic [PW-1:0]      bp_r, bp_nxt;
  logic [PW-1:0]      tp_r, tp_nxt;
  logic [15:0]        known_r, known_nxt;
  trk_t               btrk_r, btrk_nxt;
  trk_t               ttrk_r, ttrk_nxt;
  cmd_t               cmd_r, cmd_nxt;

  logic          b_we, t_we;
  logic [15:0]   b_rd, t_rd;
  logic [PW-1:0] max_pts;
  brk_t          bb, tb;

  assign max_pts = (bp_r > tp_r) ? bp_r : tp_r;
  assign bb      = bracket(btrk_r);
  assign tb      = bracket(ttrk_r);

  glb_ram #(.WIDTH(16), .DEPTH(AXIS_POINTS)) u_batch_axis (
    .clk   (clk),
    .we    (b_we),
    .waddr (bp_r[AW-1:0]),
    .wdata (b_r),
    .raddr (idx_r[AW-1:0]),
    .rdata (b_rd)
  );

  glb_ram #(.WIDTH(16), .DEPTH(AXIS_POINTS)) u_thread_axis (
    .clk   (clk),
    .we    (t_we),
    .waddr (tp_r[AW-1:0]),
    .wdata (t_r),
    .raddr (idx_r[AW-1:0]),
    .rdata (t_rd)
  );

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    w_nxt     = w_r;
    b_nxt     = b_r;
    t_nxt     = t_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    bp_nxt    = bp_r;
    tp_nxt    = tp_r;
    known_nxt = known_r;
    btrk_nxt  = btrk_r;
    ttrk_nxt  = ttrk_r;
    cmd_nxt   = cmd_r;
    b_we      = 1'b0;
    t_we      = 1'b0;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (acc) begin
          kind_nxt = in_kind;
          w_nxt    = in_workload;
          b_nxt    = in_batch;
          t_nxt    = in_threads;
          val_nxt  = in_value;
          idx_nxt  = '0;
          btrk_nxt = '0;
          ttrk_nxt = '0;
          cmd_nxt  = '0;
          cmd_nxt.op = OP_ERR;
          if (!(int'(in_workload) < WORKLOADS)) begin
            cmd_nxt.status = ST_BAD;
            state_nxt      = F_PUSH;
          end else if (in_kind && (in_batch == 16'd0 || in_threads == 16'd0)) begin
            cmd_nxt.status = ST_BAD;
            state_nxt      = F_PUSH;
          end else if (in_kind && !known_r[in_workload]) begin
            cmd_nxt.status = ST_UNKNOWN;
            state_nxt      = F_PUSH;
          end else begin
            state_nxt = (max_pts != '0) ? F_RD : F_DEC;
          end
        end
      end
      F_RD: begin
        state_nxt = F_CMP;
      end
      F_CMP: begin
        if (idx_r < bp_r) begin
          btrk_nxt = trk_step(btrk_r, b_rd, SLOT_W'(idx_r), b_r);
        end
        if (idx_r < tp_r) begin
          ttrk_nxt = trk_step(ttrk_r, t_rd, SLOT_W'(idx_r), t_r);
        end
        idx_nxt   = idx_r + PW'(1);
        state_nxt = (idx_nxt >= max_pts) ? F_DEC : F_RD;
      end
      F_DEC: begin
        state_nxt   = F_PUSH;
        cmd_nxt.wl  = w_r;
        cmd_nxt.pb  = b_r;
        cmd_nxt.pt  = t_r;
        cmd_nxt.value = val_r;
        if (!kind_r) begin
          if ((!btrk_r.found && bp_r >= PW'(AXIS_POINTS)) ||
              (!ttrk_r.found && tp_r >= PW'(AXIS_POINTS))) begin
            cmd_nxt.status = ST_FULL;
          end else begin
            cmd_nxt.op = OP_WR;
            cmd_nxt.b1 = btrk_r.found ? btrk_r.fslot : SLOT_W'(bp_r);
            cmd_nxt.t1 = ttrk_r.found ? ttrk_r.fslot : SLOT_W'(tp_r);
            if (!btrk_r.found) begin
              b_we   = 1'b1;
              bp_nxt = bp_r + PW'(1);
            end
            if (!ttrk_r.found) begin
              t_we   = 1'b1;
              tp_nxt = tp_r + PW'(1);
            end
            known_nxt[w_r] = 1'b1;
          end
        end else if ((!btrk_r.found && bp_r < PW'(2)) ||
                     (!ttrk_r.found && tp_r < PW'(2))) begin
          cmd_nxt.status = ST_FEW;
        end else begin
          cmd_nxt.b1  = btrk_r.found ? btrk_r.fslot : bb.s1;
          cmd_nxt.b2  = bb.s2;
          cmd_nxt.t1  = ttrk_r.found ? ttrk_r.fslot : tb.s1;
          cmd_nxt.t2  = tb.s2;
          cmd_nxt.xb1 = bb.x1;
          cmd_nxt.xb2 = bb.x2;
          cmd_nxt.xt1 = tb.x1;
          cmd_nxt.xt2 = tb.x2;
          if (btrk_r.found && ttrk_r.found) begin
            cmd_nxt.op = OP_EXACT;
          end else if (btrk_r.found) begin
            cmd_nxt.op = OP_LT;
          end else if (ttrk_r.found) begin
            cmd_nxt.op = OP_LB;
          end else begin
            cmd_nxt.op = OP_BI;
          end
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      bp_r    <= '0;
      tp_r    <= '0;
      known_r <= '0;
    end else begin
      state_r <= state_nxt;
      bp_r    <= bp_nxt;
      tp_r    <= tp_nxt;
      known_r <= known_nxt;
    end
    kind_r <= kind_nxt;
    w_r    <= w_nxt;
    b_r    <= b_nxt;
    t_r    <= t_nxt;
    val_r  <= val_nxt;
    idx_r  <= idx_nxt;
    btrk_r <= btrk_nxt;
    ttrk_r <= ttrk_nxt;
    cmd_r  <= cmd_nxt;
  end

  assign q_din      = cmd_r;
  assign front_busy = (state_r != F_IDLE);

endmodule

// File: rtl/glb_back.sv
// glb_back: cell store with clearing pass, cell reads and shared lerp unit
// with multiplier and bit-serial divider; depends on glb_pkg and glb_ram
module glb_back import glb_pkg::*; #(
  parameter int WORKLOADS   = 16,
  parameter int AXIS_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  cmd_t               q_dout,
  output logic               q_pop,
  output logic               back_busy,
  output logic               out_valid,
  output logic signed [31:0] out_result,
  output logic [2:0]         out_status
);

  localparam int CELLS = WORKLOADS * AXIS_POINTS * AXIS_POINTS;
  localparam int CW    = $clog2(CELLS);
  localparam int MAG_W = 48;
  localparam int NW    = $clog2(MAG_W);

  localparam logic [3:0] B_CLR  = 4'd0;
  localparam logic [3:0] B_IDLE = 4'd1;
  localparam logic [3:0] B_RD   = 4'd2;
  localparam logic [3:0] B_CAP  = 4'd3;
  localparam logic [3:0] B_MUL  = 4'd4;
  localparam logic [3:0] B_DSET = 4'd5;
  localparam logic [3:0] B_DIV  = 4'd6;
  localparam logic [3:0] B_ADD  = 4'd7;

  localparam logic [1:0] LS_B01 = 2'd0;
  localparam logic [1:0] LS_B23 = 2'd1;
  localparam logic [1:0] LS_T02 = 2'd2;

  function automatic logic [CW-1:0] cell_addr(logic [3:0] w, logic [SLOT_W-1:0] b,
                                              logic [SLOT_W-1:0] t);
    return CW'(w) * CW'(AXIS_POINTS * AXIS_POINTS) + CW'(b) * CW'(AXIS_POINTS) + CW'(t);
  endfunction

  logic [3:0]         state_r, state_nxt;
  logic [CW-1:0]      clr_r, clr_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [1:0]         k_r, k_nxt;
  logic signed [31:0] y_r [4];
  logic signed [31:0] y_nxt [4];
  logic [1:0]         ls_r, ls_nxt;
  logic signed [49:0] prod_r, prod_nxt;
  logic signed [16:0] den_r, den_nxt;
  logic signed [31:0] y1_r, y1_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [15:0]        dmag_r, dmag_nxt;
  logic               neg_r, neg_nxt;
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic               ov_r, ov_nxt;
  logic signed [31:0] ores_r, ores_nxt;
  logic [2:0]         ost_r, ost_nxt;

  logic               we;
  logic [CW-1:0]      waddr, raddr;
  logic [31:0]        wdata, rdata;

  logic [15:0]        sx1, sx2, sp;
  logic signed [31:0] ya, yb;
  logic signed [32:0] dy;
  logic signed [16:0] dx, dn;
  logic [16:0]        rsh;
  logic [49:0]        pabs;
  logic signed [48:0] q;
  logic signed [49:0] sum;
  logic signed [31:0] sat;

  glb_ram #(.WIDTH(32), .DEPTH(CELLS)) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (ls_r == LS_T02) begin
      sx1 = cmd_r.xt1;
      sx2 = cmd_r.xt2;
      sp  = cmd_r.pt;
      ya  = y_r[0];
      yb  = y_r[2];
    end else if (ls_r == LS_B23) begin
      sx1 = cmd_r.xb1;
      sx2 = cmd_r.xb2;
      sp  = cmd_r.pb;
      ya  = y_r[2];
      yb  = y_r[3];
    end else begin
      sx1 = cmd_r.xb1;
      sx2 = cmd_r.xb2;
      sp  = cmd_r.pb;
      ya  = y_r[0];
      yb  = y_r[1];
    end
    dy   = {yb[31], yb} - {ya[31], ya};
    dx   = {1'b0, sp} - {1'b0, sx1};
    dn   = {1'b0, sx2} - {1'b0, sx1};
    rsh  = {rem_r, mag_r[MAG_W-1]};
    pabs = prod_r[49] ? 50'(-prod_r) : 50'(prod_r);
    q    = neg_r ? -{1'b0, mag_r} : {1'b0, mag_r};
    sum  = {{18{y1_r[31]}}, y1_r} + {q[48], q};
    if (sum[49:31] == {19{sum[49]}}) begin
      sat = sum[31:0];
    end else begin
      sat = sum[49] ? 32'sh80000000 : 32'sh7fffffff;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cmd_nxt   = cmd_r;
    k_nxt     = k_r;
    y_nxt     = y_r;
    ls_nxt    = ls_r;
    prod_nxt  = prod_r;
    den_nxt   = den_r;
    y1_nxt    = y1_r;
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    dmag_nxt  = dmag_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = 1'b0;
    ores_nxt  = ores_r;
    ost_nxt   = ost_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = clr_r;
    wdata     = '0;
    raddr     = cell_addr(cmd_r.wl, k_r[0] ? cmd_r.b2 : cmd_r.b1,
                          k_r[1] ? cmd_r.t2 : cmd_r.t1);
    case (state_r)
      B_CLR: begin
        we      = 1'b1;
        clr_nxt = clr_r + CW'(1);
        if (clr_r == CW'(CELLS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_dout;
          k_nxt   = 2'd0;
          if (q_dout.op == OP_ERR) begin
            ov_nxt   = 1'b1;
            ores_nxt = '0;
            ost_nxt  = q_dout.status;
          end else if (q_dout.op == OP_WR) begin
            we       = 1'b1;
            waddr    = cell_addr(q_dout.wl, q_dout.b1, q_dout.t1);
            wdata    = q_dout.value;
            ov_nxt   = 1'b1;
            ores_nxt = '0;
            ost_nxt  = ST_OK;
          end else begin
            state_nxt = B_RD;
          end
        end
      end
      B_RD: begin
        state_nxt = B_CAP;
      end
      B_CAP: begin
        y_nxt[k_r] = rdata;
        k_nxt      = k_r + 2'd1;
        state_nxt  = B_RD;
        if (k_r == 2'd3) begin
          state_nxt = B_MUL;
          ls_nxt    = (cmd_r.op == OP_LT) ? LS_T02 : LS_B01;
          if (cmd_r.op == OP_EXACT) begin
            state_nxt = B_IDLE;
            ov_nxt    = 1'b1;
            ores_nxt  = y_r[0];
            ost_nxt   = ST_OK;
          end
        end
      end
      B_MUL: begin
        prod_nxt  = dy * dx;
        den_nxt   = dn;
        y1_nxt    = ya;
        state_nxt = B_DSET;
      end
      B_DSET: begin
        mag_nxt   = pabs[MAG_W-1:0];
        dmag_nxt  = den_r[16] ? 16'(-den_r) : den_r[15:0];
        neg_nxt   = prod_r[49] ^ den_r[16];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = B_DIV;
        if (den_r == '0) begin
          mag_nxt   = '0;
          state_nxt = B_ADD;
        end
      end
      B_DIV: begin
        if (rsh >= {1'b0, dmag_r}) begin
          rem_nxt = 16'(rsh - {1'b0, dmag_r});
          mag_nxt = {mag_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_nxt = rsh[15:0];
          mag_nxt = {mag_r[MAG_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + NW'(1);
        if (cnt_r == NW'(MAG_W - 1)) begin
          state_nxt = B_ADD;
        end
      end
      B_ADD: begin
        if (cmd_r.op == OP_BI && ls_r == LS_B01) begin
          y_nxt[0]  = sat;
          ls_nxt    = LS_B23;
          state_nxt = B_MUL;
        end else if (cmd_r.op == OP_BI && ls_r == LS_B23) begin
          y_nxt[2]  = sat;
          ls_nxt    = LS_T02;
          state_nxt = B_MUL;
        end else begin
          ov_nxt    = 1'b1;
          ores_nxt  = sat;
          ost_nxt   = ST_OK;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    cmd_r  <= cmd_nxt;
    k_r    <= k_nxt;
    y_r    <= y_nxt;
    ls_r   <= ls_nxt;
    prod_r <= prod_nxt;
    den_r  <= den_nxt;
    y1_r   <= y1_nxt;
    mag_r  <= mag_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    ores_r <= ores_nxt;
    ost_r  <= ost_nxt;
  end

  assign back_busy  = (state_r != B_IDLE);
  assign out_valid  = ov_r;
  assign out_result = ores_r;
  assign out_status = ost_r;

endmodule

// File: verif/testbench.sv
// testbench: drives load and query beats into grid_bilinear_lookup, checks each result
// beat vs an in-bench latency table predictor or typed row; depends on glb_pkg, the rtl
module testbench import glb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit KIND_LOAD  = 1'b0;
  localparam bit KIND_QUERY = 1'b1;
  localparam int NPTS       = 16;
  localparam int NWL        = 16;
  localparam int N_RANDOM   = 1200;
  localparam int IDLE_LIMIT = 20000;
  localparam int POOL       = 24;

  typedef struct {
    logic signed [31:0] res;
    status_t            st;
  } lat_beat_t;

  typedef struct {
    bit                 kind;
    logic [3:0]         wl;
    logic [15:0]        b;
    logic [15:0]        t;
    logic signed [31:0] v;
    bit                 typed;
    logic signed [31:0] res;
    status_t            st;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_kind = 1'b0;
  logic [3:0]         in_workload = '0;
  logic [15:0]        in_batch = '0;
  logic [15:0]        in_threads = '0;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic signed [31:0] out_result;
  logic [2:0]         out_status;

  bit                 cur_typed = 1'b0;
  logic signed [31:0] cur_res = '0;
  status_t            cur_st = ST_OK;

  lat_beat_t   lat_q[$];
  int          errors = 0;
  int          idle_cycles = 0;

  bit          wl_known[NWL];
  logic [15:0] bat_axis[NPTS];
  logic [15:0] thr_axis[NPTS];
  int          n_bat;
  int          n_thr;
  logic signed [31:0] cells[NWL][NPTS][NPTS];

  logic [15:0] bpool[POOL];
  logic [15:0] tpool[POOL];

  dir_row_t dir_rows[16] = '{
    '{KIND_QUERY, 4'd0,  16'd1,     16'd1,     32'sd0,        1, 32'sd0, ST_UNKNOWN},
    '{KIND_QUERY, 4'd0,  16'd0,     16'd5,     32'sd0,        1, 32'sd0, ST_BAD},
    '{KIND_QUERY, 4'd0,  16'd5,     16'd0,     32'sd0,        1, 32'sd0, ST_BAD},
    '{KIND_LOAD,  4'd0,  16'd100,   16'd10,    32'h7fffffff,  1, 32'sd0, ST_OK},
    '{KIND_QUERY, 4'd0,  16'd100,   16'd10,    32'sd0,        1, 32'h7fffffff, ST_OK},
    '{KIND_QUERY, 4'd0,  16'd200,   16'd10,    32'sd0,        1, 32'sd0, ST_FEW},
    '{KIND_QUERY, 4'd0,  16'd100,   16'd20,    32'sd0,        1, 32'sd0, ST_FEW},
    '{KIND_LOAD,  4'd0,  16'd300,   16'd10,    32'h80000000,  1, 32'sd0, ST_OK},
    '{KIND_QUERY, 4'd0,  16'd200,   16'd10,    32'sd0,        0, 32'sd0, ST_OK},
    '{KIND_QUERY, 4'd0,  16'd65535, 16'd10,    32'sd0,        0, 32'sd0, ST_OK},
    '{KIND_LOAD,  4'd15, 16'd0,     16'd65535, 32'hffffffff,  1, 32'sd0, ST_OK},
    '{KIND_LOAD,  4'd0,  16'd100,   16'd30,    32'sd12345,    1, 32'sd0, ST_OK},
    '{KIND_QUERY, 4'd0,  16'd50,    16'd20,    32'sd0,        0, 32'sd0, ST_OK},
    '{KIND_QUERY, 4'd15, 16'd100,   16'd65535, 32'sd0,        1, 32'sd0, ST_OK},
    '{KIND_QUERY, 4'd3,  16'd65535, 16'd65535, 32'sd0,        1, 32'sd0, ST_UNKNOWN},
    '{KIND_LOAD,  4'd15, 16'd65535, 16'd1,     32'sh00010000, 1, 32'sd0, ST_OK}
  };

  grid_bilinear_lookup u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_workload(in_workload), .in_batch(in_batch),
    .in_threads(in_threads), .in_value(in_value),
    .out_valid(out_valid), .out_result(out_result), .out_status(out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int find_slot(input logic [15:0] ax[NPTS], input int n,
                                   input logic [15:0] v);
    for (int i = 0; i < n; i++) if (ax[i] == v) return i;
    return -1;
  endfunction

  function automatic int nearest_pt(input logic [15:0] ax[NPTS], input int n,
                                    input logic [15:0] v, input bit up);
    int best;
    best = -1;
    for (int i = 0; i < n; i++) begin
      if (up ? (ax[i] > v) : (ax[i] < v)) begin
        if (best < 0 || (up ? (ax[i] < ax[best]) : (ax[i] > ax[best]))) best = i;
      end
    end
    return best;
  endfunction

  task automatic bracket_pts(input logic [15:0] ax[NPTS], input int n,
                             input logic [15:0] p, output int s1, output int s2);
    int lo, hi;
    lo = nearest_pt(ax, n, p, 1'b0);
    hi = nearest_pt(ax, n, p, 1'b1);
    if (lo < 0) begin
      s1 = hi;
      s2 = nearest_pt(ax, n, ax[hi], 1'b1);
    end else if (hi < 0) begin
      s2 = lo;
      s1 = nearest_pt(ax, n, ax[lo], 1'b0);
    end else begin
      s1 = lo;
      s2 = hi;
    end
  endtask

  function automatic logic signed [31:0] lerp_q16(input longint x1, input longint y1,
                                                  input longint x2, input longint y2,
                                                  input longint p);
    longint den, sum;
    den = x2 - x1;
    if (den == 0) return y1[31:0];
    sum = y1 + ((y2 - y1) * (p - x1)) / den;
    if (sum > 64'sd2147483647) return 32'h7fffffff;
    if (sum < -64'sd2147483648) return 32'h80000000;
    return sum[31:0];
  endfunction

  task automatic predict_latency(input bit kind, input logic [3:0] wl, input logic [15:0] b,
                                 input logic [15:0] t, input logic signed [31:0] v,
                                 output lat_beat_t o);
    int bs, ts, b1, b2, t1, t2;
    logic signed [31:0] first, second;
    o.res = '0;
    o.st = ST_OK;
    bs = find_slot(bat_axis, n_bat, b);
    ts = find_slot(thr_axis, n_thr, t);
    if (kind == KIND_LOAD) begin
      if ((bs < 0 && n_bat >= NPTS) || (ts < 0 && n_thr >= NPTS)) begin
        o.st = ST_FULL;
      end else begin
        if (bs < 0) begin
          bs = n_bat;
          bat_axis[n_bat++] = b;
        end
        if (ts < 0) begin
          ts = n_thr;
          thr_axis[n_thr++] = t;
        end
        wl_known[wl] = 1'b1;
        cells[wl][bs][ts] = v;
      end
    end else if (b == 0 || t == 0) begin
      o.st = ST_BAD;
    end else if (!wl_known[wl]) begin
      o.st = ST_UNKNOWN;
    end else if ((bs < 0 && n_bat < 2) || (ts < 0 && n_thr < 2)) begin
      o.st = ST_FEW;
    end else if (bs >= 0 && ts >= 0) begin
      o.res = cells[wl][bs][ts];
    end else if (bs >= 0) begin
      bracket_pts(thr_axis, n_thr, t, t1, t2);
      o.res = lerp_q16(thr_axis[t1], cells[wl][bs][t1], thr_axis[t2], cells[wl][bs][t2], t);
    end else if (ts >= 0) begin
      bracket_pts(bat_axis, n_bat, b, b1, b2);
      o.res = lerp_q16(bat_axis[b1], cells[wl][b1][ts], bat_axis[b2], cells[wl][b2][ts], b);
    end else begin
      bracket_pts(thr_axis, n_thr, t, t1, t2);
      bracket_pts(bat_axis, n_bat, b, b1, b2);
      first = lerp_q16(bat_axis[b1], cells[wl][b1][t1], bat_axis[b2], cells[wl][b2][t1], b);
      second = lerp_q16(bat_axis[b1], cells[wl][b1][t2], bat_axis[b2], cells[wl][b2][t2], b);
      o.res = lerp_q16(thr_axis[t1], first, thr_axis[t2], second, t);
    end
  endtask

  // accepted beats feed the predictor
  always @(posedge clk) begin
    lat_beat_t p;
    if (rst_n && start && !busy) begin
      predict_latency(in_kind, in_workload, in_batch, in_threads, in_value, p);
      if (cur_typed) begin
        p.res = cur_res;
        p.st = cur_st;
      end
      lat_q = {lat_q, p};
    end
  end

  always @(posedge clk) begin
    lat_beat_t e;
    if (rst_n && out_valid) begin
      if (lat_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: result %h status %0d",
                                   out_result, out_status);
      end else begin
        e = lat_q.pop_front();
        if (out_result !== e.res || out_status !== e.st) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: result %h status %0d, expected result %h status %0d",
                     out_result, out_status, e.res, e.st);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog timeout");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_beat(input bit kind, input logic [3:0] wl, input logic [15:0] b,
                           input logic [15:0] t, input logic signed [31:0] v,
                           input bit typed, input logic signed [31:0] res,
                           input status_t st);
    start <= 1'b1;
    in_kind <= kind;
    in_workload <= wl;
    in_batch <= b;
    in_threads <= t;
    in_value <= v;
    cur_typed <= typed;
    cur_res <= res;
    cur_st <= st;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  function automatic logic [15:0] pick_coord(input bit isb, input bit query);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return isb ? bpool[$urandom_range(0, POOL - 1)] : tpool[$urandom_range(0, POOL - 1)];
    if (r < 95) return 16'($urandom);
    return query ? 16'd0 : 16'($urandom_range(0, 3));
  endfunction

  initial begin
    int burst;
    bit kind;
    logic signed [31:0] v;
    for (int i = 0; i < NWL; i++) wl_known[i] = 1'b0;
    for (int w = 0; w < NWL; w++)
      for (int i = 0; i < NPTS; i++)
        for (int j = 0; j < NPTS; j++) cells[w][i][j] = '0;
    n_bat = 0;
    n_thr = 0;
    for (int i = 0; i < POOL; i++) begin
      bpool[i] = 16'($urandom_range(1, 65535));
      tpool[i] = 16'($urandom_range(1, 65535));
    end
    bpool[0] = 16'd1;
    bpool[1] = 16'd65535;
    tpool[0] = 16'd1;
    tpool[1] = 16'd65535;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].kind, dir_rows[i].wl, dir_rows[i].b, dir_rows[i].t, dir_rows[i].v,
                dir_rows[i].typed, dir_rows[i].res, dir_rows[i].st);
      if ($urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end

    burst = $urandom_range(1, 30);
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = ($urandom_range(0, 99) < 40) ? KIND_LOAD : KIND_QUERY;
      v = ($urandom_range(0, 1) == 0) ? 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000)
                                     : 32'($urandom);
      send_beat(kind,
                ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4)),
                pick_coord(1'b1, kind), pick_coord(1'b0, kind), v, 1'b0, '0, ST_OK);
      if (--burst == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        burst = $urandom_range(1, 30);
      end
    end
    start <= 1'b0;

    while (lat_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
rtl/glb_pkg.sv
rtl/glb_ram.sv
rtl/glb_queue.sv
rtl/glb_front.sv
rtl/glb_back.sv
rtl/grid_bilinear_lookup.sv
verif/testbench.sv
